// ===== design/wbps_pkg.sv =====
// shared constants, register indexes and types for the wildcard byte pattern scanner
package wbps_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int OFFSET_WIDTH = 32;
    localparam int CFG_BYTES    = 16;
    localparam int LEN_MAX      = (MAX_PATTERN < CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;
    localparam int IDX_W        = $clog2(LEN_MAX);
    localparam int LEN_W        = $clog2(LEN_MAX + 1);
    localparam int OUT_OFFSET_W = 32;
    localparam int COUNT_W      = 16;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [4:0]         PATTERN_LENGTH_RESET = 5'd1;
    localparam logic [COUNT_W-1:0] MAX_MATCHES_RESET    = 16'd32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_MAX_MATCHES  = 3'd4
    } cfg_reg_t;

    typedef logic [LEN_MAX-1:0][7:0] pattern_t;

    typedef struct packed {
        pattern_t             pattern;
        logic [LEN_MAX-1:0]   wild;
        logic [LEN_W-1:0]     len;
    } match_cfg_t;

endpackage

// ===== design/wbps_cell.sv =====
// one window cell: holds a byte and its fill bit, compares its window slot to the pattern
module wbps_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  logic                       clear,
    input  logic [wbps_pkg::IDX_W-1:0] cell_index,
    input  wbps_pkg::match_cfg_t       match_cfg,
    input  logic [7:0]                 byte_in,
    input  logic                       valid_in,
    output logic [7:0]                 byte_out,
    output logic                       valid_out,
    output logic                       cell_ok
);
    import wbps_pkg::*;

    logic [7:0]       byte_reg;
    logic             valid_reg;
    logic             in_use;
    logic [LEN_W-1:0] sel_wide;
    logic [IDX_W-1:0] sel;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= clear ? 1'b0 : valid_in;
        end
    end

    // slot i of the window meets pattern byte len-1-i
    always_comb begin
        in_use   = LEN_W'(cell_index) < match_cfg.len;
        sel_wide = match_cfg.len - LEN_W'(1) - LEN_W'(cell_index);
        sel      = sel_wide[IDX_W-1:0];
        cell_ok  = !in_use ||
                   (valid_in && (match_cfg.wild[sel] || byte_in == match_cfg.pattern[sel]));
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

// ===== design/wildcard_byte_pattern_scanner.sv =====
// top level of the wildcard byte pattern scanner: config registers, cell row, result register
//
// Usage: bytes of a buffer arrive on the s_ channel, one per request, s_tdata[7:0] holding
// the byte and s_tlast marking the final byte. A row of 16 cells holds the latest bytes and
// compares them, wildcards included, against the configured pattern in the same cycle the
// byte is taken. Each match gives one request on the m_ channel with m_tuser set and the
// start offset in m_tdata[31:0]; the final byte always gives a request with m_tlast set.
// m_tdata[47:32] carries the number of matches reported so far, capped at max_matches;
// once the cap is reached further matches are dropped.
// The result of an accepted byte is held in the output register from the next cycle on.
// Throughput is one byte per cycle unless the receiver stalls; the row compares combinationally.
// s_tready drops only while a result sits in the output register and m_tready is low,
// so a stalled receiver holds the input for exactly as long as it stalls.
// Configuration writes on the cfg_ channel are always taken and must be made while idle.
// Reset (aresetn low, synchronous) loads the register defaults, empties the window and
// clears the offset and match counters; the final byte of each buffer clears them too.
module wildcard_byte_pattern_scanner (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // data_byte[7:0]
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [47:0]                          m_tdata,   // match_offset[31:0], match_total[47:32]
    output logic                                 m_tuser,   // match_found
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wbps_pkg::*;

    logic [63:0]             pat_low_reg;
    logic [63:0]             pat_high_reg;
    logic [15:0]             wild_reg;
    logic [4:0]              len_cfg_reg;
    logic [COUNT_W-1:0]      max_reg;

    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    m_found_reg;
    logic                    m_last_reg;
    logic [OUT_OFFSET_W-1:0] m_offset_reg;
    logic [COUNT_W-1:0]      m_total_reg;

    logic                    s_accept;
    logic                    hit;
    logic                    produce;
    logic [4:0]              len_sat;
    logic [127:0]            pat_all;
    match_cfg_t              match_cfg;
    logic [OFFSET_WIDTH-1:0] offset;
    logic [OFFSET_WIDTH+OUT_OFFSET_W-1:0] offset_wide;

    logic [LEN_MAX-1:0][7:0] chain_byte;
    logic [LEN_MAX-1:0]      chain_valid;
    logic [LEN_MAX-1:0][7:0] cell_byte_out;
    logic [LEN_MAX-1:0]      cell_valid_out;
    logic [LEN_MAX-1:0]      cell_ok;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_cfg_reg  <= PATTERN_LENGTH_RESET;
            max_reg      <= MAX_MATCHES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_WILDCARD:     wild_reg     <= cfg_data[15:0];
                REG_LENGTH:       len_cfg_reg  <= cfg_data[4:0];
                REG_MAX_MATCHES:  max_reg      <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        pat_all = {pat_high_reg, pat_low_reg};
        if (len_cfg_reg == 5'd0) begin
            len_sat = 5'd1;
        end else if (len_cfg_reg > 5'(LEN_MAX)) begin
            len_sat = 5'(LEN_MAX);
        end else begin
            len_sat = len_cfg_reg;
        end
        for (int k = 0; k < LEN_MAX; k++) begin
            match_cfg.pattern[k] = pat_all[8*k +: 8];
        end
        match_cfg.wild = wild_reg[LEN_MAX-1:0];
        match_cfg.len  = LEN_W'(len_sat);
    end

    // cell 0 sees the incoming byte, each later cell the byte held by its neighbor
    always_comb begin
        chain_byte[0]  = s_tdata;
        chain_valid[0] = 1'b1;
        for (int k = 1; k < LEN_MAX; k++) begin
            chain_byte[k]  = cell_byte_out[k-1];
            chain_valid[k] = cell_valid_out[k-1];
        end
    end

    for (genvar g = 0; g < LEN_MAX; g++) begin : g_cell
        wbps_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (s_accept),
            .clear      (s_tlast),
            .cell_index (IDX_W'(g)),
            .match_cfg  (match_cfg),
            .byte_in    (chain_byte[g]),
            .valid_in   (chain_valid[g]),
            .byte_out   (cell_byte_out[g]),
            .valid_out  (cell_valid_out[g]),
            .cell_ok    (cell_ok[g])
        );
    end

    always_comb begin
        hit         = (&cell_ok) && (count_reg < max_reg);
        produce     = hit || s_tlast;
        offset      = pos_reg - OFFSET_WIDTH'(match_cfg.len - LEN_W'(1));
        offset_wide = (OFFSET_WIDTH + OUT_OFFSET_W)'(offset);
        count_next  = count_reg + COUNT_W'(hit);
        pos_next    = pos_reg + OFFSET_WIDTH'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
        end else if (s_accept) begin
            pos_reg   <= s_tlast ? '0 : pos_next;
            count_reg <= s_tlast ? '0 : count_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_tready) begin
            m_valid_next = s_accept && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && produce) begin
            m_found_reg  <= hit;
            m_last_reg   <= s_tlast;
            m_offset_reg <= hit ? offset_wide[OUT_OFFSET_W-1:0] : '0;
            m_total_reg  <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_offset_reg};
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_found_reg |-> m_total_reg != '0)
        else $error("reported match with zero total");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> pos_reg == '0 && count_reg == '0 && cell_valid_out == '0)
        else $error("scan state not cleared after final byte");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_valid_reg && !m_tready)
        else $error("input stalled without a held result");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tlast |=> count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1)
        else $error("match count moved by more than one");

endmodule
